// ===== hw/rtl/takeoff_landing_thrust_sequencer_unit_defines.svh =====
`ifndef TAKEOFF_LANDING_THRUST_SEQUENCER_UNIT_DEFINES_SVH
`define TAKEOFF_LANDING_THRUST_SEQUENCER_UNIT_DEFINES_SVH

// Checks a condition in the same cycle as its trigger.
`define TLTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tlts check failed");

// Checks a condition in the cycle after its trigger.
`define TLTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tlts check failed");

`endif

// ===== hw/rtl/tlts_pkg.sv =====
`timescale 1ns / 1ps
package tlts_pkg;

  localparam int RAMP_COUNT_WIDTH = 10;
  localparam int CONFIRM_TICKS    = 10;

  localparam int THRUST_W = 16;
  localparam int STEPS_W  = 10;
  localparam int COUNT_W  = 4;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_MIN_THRUST  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAX_THRUST  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RAMP_STEPS  = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_RAMP_FACTOR = 2'd3;

  localparam logic [THRUST_W-1:0] MIN_THRUST_RST  = 16'd0;
  localparam logic [THRUST_W-1:0] MAX_THRUST_RST  = 16'd58982;
  localparam logic [STEPS_W-1:0]  RAMP_STEPS_RST  = 10'd100;
  localparam logic [THRUST_W-1:0] RAMP_FACTOR_RST = 16'd655;

  localparam logic [1:0] PH_GROUND = 2'd0;
  localparam logic [1:0] PH_SLOW   = 2'd1;
  localparam logic [1:0] PH_FLYING = 2'd2;
  localparam logic [1:0] PH_UNUSED = 2'd3;

  localparam logic signed [15:0] TH_CMD_POS  = 16'sd204;
  localparam logic signed [15:0] TH_CMD_NEG  = -16'sd204;
  localparam logic signed [15:0] TH_CMD_LAND = -16'sd2048;
  localparam logic signed [15:0] TH_VZ       = -16'sd512;
  localparam logic signed [15:0] TH_VXY      = 16'sd204;

  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int QUO_W     = 32;
  localparam int PROD1_W   = QUO_W + RAMP_COUNT_WIDTH;
  localparam int PROD2_W   = PROD1_W + THRUST_W;
  localparam int SCALED_W  = PROD2_W - THRUST_W;
  localparam int CMP_W     = (RAMP_COUNT_WIDTH > STEPS_W) ? RAMP_COUNT_WIDTH : STEPS_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX     = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] CONFIRM_COUNT = COUNT_W'(CONFIRM_TICKS);

endpackage

// ===== hw/rtl/takeoff_landing_thrust_sequencer_unit.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_ready   mode, command, velocities, accel, gain
// out_     output     out_valid / out_ready thrust_command, flight_phase, gain_invalid
// cfg_     input      cfg_we                cfg_index, cfg_data
//
// After acceptance a request runs through the restoring divider, one quotient bit per
// cycle, then the multiply states ST_MUL1 and ST_MUL2 and the clamp state ST_CLAMP.
// in_ready is high only while the sequencer is idle, so a new request is accepted only
// after the last result is taken; a result held by a stalled out_ready keeps it busy.
// Reset is synchronous and active low; it restores the phase, the takeoff, landing and ramp
// counters and the configuration registers to their documented reset values.
`include "takeoff_landing_thrust_sequencer_unit_defines.svh"
module takeoff_landing_thrust_sequencer_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_mode,
  input  logic signed [15:0]                   in_vertical_command,
  input  logic signed [15:0]                   in_vel_x,
  input  logic signed [15:0]                   in_vel_y,
  input  logic signed [15:0]                   in_vel_z,
  input  logic signed [15:0]                   in_accel_z_wanted,
  input  logic signed [15:0]                   in_accel_per_thrust,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [tlts_pkg::THRUST_W-1:0]        out_thrust_command,
  output logic [1:0]                           out_flight_phase,
  output logic                                 out_gain_invalid,
  input  logic                                 cfg_we,
  input  logic [tlts_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [tlts_pkg::THRUST_W-1:0]        cfg_data
);
  import tlts_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL1,
    ST_MUL2,
    ST_CLAMP,
    ST_OUT
  } state_t;

  state_t                      state_r, state_nxt;
  logic [1:0]                  phase_r, phase_nxt;
  logic [COUNT_W-1:0]          takeoff_r, takeoff_nxt;
  logic [COUNT_W-1:0]          landing_r, landing_nxt;
  logic [RAMP_COUNT_WIDTH-1:0] ramp_r, ramp_nxt;
  logic [THRUST_W-1:0]         min_r, min_nxt;
  logic [THRUST_W-1:0]         max_r, max_nxt;
  logic [STEPS_W-1:0]          steps_r, steps_nxt;
  logic [THRUST_W-1:0]         factor_r, factor_nxt;

  logic [15:0]                 rem_r, rem_nxt;
  logic [QUO_W-1:0]            quo_r, quo_nxt;
  logic [15:0]                 divisor_r, divisor_nxt;
  logic [DIV_CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                        sgn_r, sgn_nxt;
  logic                        neg_r, neg_nxt;
  logic                        invalid_r, invalid_nxt;
  logic [PROD1_W-1:0]          prod1_r, prod1_nxt;
  logic [PROD2_W-1:0]          prod2_r, prod2_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [THRUST_W-1:0]         thrust_r, thrust_nxt;
  logic [1:0]                  out_phase_r, out_phase_nxt;
  logic                        out_invalid_r, out_invalid_nxt;

  logic [15:0]                 acc_abs;
  logic [15:0]                 gain_abs;
  logic [16:0]                 trial;
  logic                        trial_ok;
  logic [QUO_W-1:0]            mag;
  logic [SCALED_W-1:0]         sel;
  logic [SCALED_W-1:0]         lo_val;
  logic                        land;
  logic [COUNT_W-1:0]          landing_inc;

  assign acc_abs  = in_accel_z_wanted[15] ? (~in_accel_z_wanted + 16'd1) : in_accel_z_wanted;
  assign gain_abs = in_accel_per_thrust[15] ? (~in_accel_per_thrust + 16'd1)
                                            : in_accel_per_thrust;
  assign trial    = {rem_r, quo_r[QUO_W-1]};
  assign trial_ok = trial >= {1'b0, divisor_r};
  assign mag      = invalid_r ? QUO_W'(min_r) : quo_r;

  assign land = (in_vertical_command <= TH_CMD_LAND) && (in_vel_z > TH_VZ) &&
                (in_vel_x <= TH_VXY) && (in_vel_x >= -TH_VXY) &&
                (in_vel_y <= TH_VXY) && (in_vel_y >= -TH_VXY);
  assign landing_inc = (landing_r < COUNT_MAX) ? (landing_r + 1'b1) : landing_r;

  always_comb begin
    case (phase_r)
      PH_SLOW:   sel = prod2_r[PROD2_W-1:THRUST_W];
      PH_FLYING: sel = SCALED_W'(quo_r);
      default:   sel = SCALED_W'(min_r);
    endcase
    if (neg_r && (phase_r == PH_SLOW || phase_r == PH_FLYING) && sel != '0) begin
      lo_val = SCALED_W'(min_r);
    end else if (sel < SCALED_W'(min_r)) begin
      lo_val = SCALED_W'(min_r);
    end else begin
      lo_val = sel;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    takeoff_nxt     = takeoff_r;
    landing_nxt     = landing_r;
    ramp_nxt        = ramp_r;
    min_nxt         = min_r;
    max_nxt         = max_r;
    steps_nxt       = steps_r;
    factor_nxt      = factor_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    divisor_nxt     = divisor_r;
    cnt_nxt         = cnt_r;
    sgn_nxt         = sgn_r;
    neg_nxt         = neg_r;
    invalid_nxt     = invalid_r;
    prod1_nxt       = prod1_r;
    prod2_nxt       = prod2_r;
    out_valid_nxt   = out_valid_r;
    thrust_nxt      = thrust_r;
    out_phase_nxt   = out_phase_r;
    out_invalid_nxt = out_invalid_r;

    if (cfg_we) begin
      case (cfg_index)
        REG_MIN_THRUST:  min_nxt    = cfg_data;
        REG_MAX_THRUST:  max_nxt    = cfg_data;
        REG_RAMP_STEPS:  steps_nxt  = cfg_data[STEPS_W-1:0];
        REG_RAMP_FACTOR: factor_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          rem_nxt     = '0;
          quo_nxt     = {acc_abs, 16'd0};
          divisor_nxt = gain_abs;
          cnt_nxt     = '0;
          sgn_nxt     = in_accel_z_wanted[15] != in_accel_per_thrust[15];
          invalid_nxt = in_accel_per_thrust == 16'sd0;
          state_nxt   = ST_DIV;
          if (in_mode) begin
            case (phase_r)
              PH_SLOW: begin
                if (CMP_W'(ramp_r) == CMP_W'(steps_r)) begin
                  phase_nxt = PH_FLYING;
                  ramp_nxt  = '0;
                end else if (in_vertical_command < TH_CMD_NEG) begin
                  phase_nxt   = PH_GROUND;
                  takeoff_nxt = '0;
                  ramp_nxt    = '0;
                end else begin
                  ramp_nxt = ramp_r + 1'b1;
                end
              end
              PH_FLYING: begin
                if (land) begin
                  landing_nxt = landing_inc;
                  if (landing_inc >= CONFIRM_COUNT) begin
                    phase_nxt   = PH_GROUND;
                    takeoff_nxt = '0;
                  end
                end else begin
                  landing_nxt = '0;
                end
              end
              default: begin
                phase_nxt = PH_GROUND;
                if (in_vertical_command > TH_CMD_POS) begin
                  if (takeoff_r < CONFIRM_COUNT) begin
                    takeoff_nxt = takeoff_r + 1'b1;
                  end else begin
                    phase_nxt   = PH_SLOW;
                    ramp_nxt    = '0;
                    landing_nxt = '0;
                  end
                end else begin
                  takeoff_nxt = '0;
                end
              end
            endcase
          end
        end
      end
      ST_DIV: begin
        rem_nxt = trial_ok ? 16'(trial - {1'b0, divisor_r}) : trial[15:0];
        quo_nxt = {quo_r[QUO_W-2:0], trial_ok};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        quo_nxt   = mag;
        neg_nxt   = sgn_r && !invalid_r && (quo_r != '0);
        prod1_nxt = PROD1_W'(mag) * PROD1_W'(ramp_r);
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        prod2_nxt = PROD2_W'(prod1_r) * PROD2_W'(factor_r);
        state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        thrust_nxt      = (lo_val > SCALED_W'(max_r)) ? max_r : lo_val[THRUST_W-1:0];
        out_phase_nxt   = phase_r;
        out_invalid_nxt = invalid_r;
        out_valid_nxt   = 1'b1;
        state_nxt       = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_GROUND;
      takeoff_r   <= '0;
      landing_r   <= '0;
      ramp_r      <= '0;
      min_r       <= MIN_THRUST_RST;
      max_r       <= MAX_THRUST_RST;
      steps_r     <= RAMP_STEPS_RST;
      factor_r    <= RAMP_FACTOR_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      takeoff_r   <= takeoff_nxt;
      landing_r   <= landing_nxt;
      ramp_r      <= ramp_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      steps_r     <= steps_nxt;
      factor_r    <= factor_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rem_r         <= rem_nxt;
    quo_r         <= quo_nxt;
    divisor_r     <= divisor_nxt;
    cnt_r         <= cnt_nxt;
    sgn_r         <= sgn_nxt;
    neg_r         <= neg_nxt;
    invalid_r     <= invalid_nxt;
    prod1_r       <= prod1_nxt;
    prod2_r       <= prod2_nxt;
    thrust_r      <= thrust_nxt;
    out_phase_r   <= out_phase_nxt;
    out_invalid_r <= out_invalid_nxt;
  end

  assign in_ready           = state_r == ST_IDLE;
  assign out_valid          = out_valid_r;
  assign out_thrust_command = thrust_r;
  assign out_flight_phase   = out_phase_r;
  assign out_gain_invalid   = out_invalid_r;

  `TLTS_ASSERT_NOW(a_busy_when_result, out_valid, !in_ready)
  `TLTS_ASSERT_NEXT(a_busy_after_request, in_valid && in_ready, !in_ready && !out_valid)
  `TLTS_ASSERT_NOW(a_thrust_below_max, out_valid, out_thrust_command <= max_r)
  `TLTS_ASSERT_NOW(a_ground_thrust, out_valid && out_flight_phase == PH_GROUND,
                   out_thrust_command == min_r || out_thrust_command == max_r)
  `TLTS_ASSERT_NOW(a_phase_code, out_valid, out_flight_phase != PH_UNUSED)

endmodule

// ===== sim/takeoff_landing_thrust_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps
module takeoff_landing_thrust_sequencer_unit_tb;
  import tlts_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic        mode;
    logic [15:0] cmd;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] vz;
    logic [15:0] acc;
    logic [15:0] gain;
  } tick_t;

  typedef struct packed {
    logic [THRUST_W-1:0] thrust;
    logic [1:0]          phase;
    logic                invalid;
  } thrust_res_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_mode;
  logic signed [15:0] in_vertical_command;
  logic signed [15:0] in_vel_x;
  logic signed [15:0] in_vel_y;
  logic signed [15:0] in_vel_z;
  logic signed [15:0] in_accel_z_wanted;
  logic signed [15:0] in_accel_per_thrust;
  logic out_valid;
  logic out_ready;
  logic [THRUST_W-1:0] out_thrust_command;
  logic [1:0] out_flight_phase;
  logic out_gain_invalid;
  logic cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [THRUST_W-1:0] cfg_data;

  // Predicted sequencer state and register copies.
  logic [1:0]                  fl_phase;
  logic [COUNT_W-1:0]          takeoff_cnt;
  logic [COUNT_W-1:0]          landing_cnt;
  logic [RAMP_COUNT_WIDTH-1:0] ramp_cnt;
  logic [THRUST_W-1:0]         min_thr;
  logic [THRUST_W-1:0]         max_thr;
  logic [STEPS_W-1:0]          ramp_len;
  logic [THRUST_W-1:0]         ramp_fac;

  thrust_res_t thrust_expected[$];
  int          mismatches = 0;
  int          ticks_sent;
  int unsigned cycle_count = 0;
  bit          tx_idle;
  bit          rx_idle;
  int          rx_hold;

  takeoff_landing_thrust_sequencer_unit dut (.*);

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic reset_model();
    fl_phase    = PH_GROUND;
    takeoff_cnt = '0;
    landing_cnt = '0;
    ramp_cnt    = '0;
    min_thr     = MIN_THRUST_RST;
    max_thr     = MAX_THRUST_RST;
    ramp_len    = RAMP_STEPS_RST;
    ramp_fac    = RAMP_FACTOR_RST;
  endtask

  function automatic thrust_res_t predict_thrust(tick_t t);
    int          c;
    int          vx;
    int          vy;
    int          vz;
    int          a;
    int          g;
    logic        land;
    logic        neg;
    logic [63:0] ua;
    logic [63:0] ug;
    logic [63:0] mag;
    longint      val;
    longint      lo;
    longint      hi;
    thrust_res_t r;
    c  = int'($signed(t.cmd));
    vx = int'($signed(t.vx));
    vy = int'($signed(t.vy));
    vz = int'($signed(t.vz));
    a  = int'($signed(t.acc));
    g  = int'($signed(t.gain));
    if (t.mode) begin
      case (fl_phase)
        PH_SLOW: begin
          if (ramp_cnt == ramp_len) begin
            fl_phase = PH_FLYING;
            ramp_cnt = '0;
          end else begin
            ramp_cnt = ramp_cnt + 1'b1;
            if (c < TH_CMD_NEG) begin
              fl_phase    = PH_GROUND;
              takeoff_cnt = '0;
              ramp_cnt    = '0;
            end
          end
        end
        PH_FLYING: begin
          land = c <= TH_CMD_LAND && vz > TH_VZ && vx <= TH_VXY && vx >= -TH_VXY &&
                 vy <= TH_VXY && vy >= -TH_VXY;
          if (land) begin
            if (landing_cnt < COUNT_MAX) landing_cnt = landing_cnt + 1'b1;
            if (landing_cnt >= CONFIRM_COUNT) begin
              fl_phase    = PH_GROUND;
              takeoff_cnt = '0;
            end
          end else begin
            landing_cnt = '0;
          end
        end
        default: begin
          fl_phase = PH_GROUND;
          if (c > TH_CMD_POS) begin
            if (takeoff_cnt < CONFIRM_COUNT) begin
              takeoff_cnt = takeoff_cnt + 1'b1;
            end else begin
              fl_phase    = PH_SLOW;
              ramp_cnt    = '0;
              landing_cnt = '0;
            end
          end else begin
            takeoff_cnt = '0;
          end
        end
      endcase
    end
    r.invalid = (g == 0);
    neg = 1'b0;
    if (r.invalid) begin
      mag = 64'(min_thr);
    end else begin
      ua  = 64'((a < 0) ? -a : a);
      ug  = 64'((g < 0) ? -g : g);
      mag = (ua << 16) / ug;
      neg = ((a < 0) != (g < 0)) && mag != 0;
    end
    if (fl_phase == PH_SLOW) mag = (mag * 64'(ramp_cnt) * 64'(ramp_fac)) >> 16;
    else if (fl_phase != PH_FLYING) mag = 64'(min_thr);
    if (fl_phase != PH_SLOW && fl_phase != PH_FLYING) neg = 1'b0;
    val = neg ? -longint'(mag) : longint'(mag);
    lo  = longint'(min_thr);
    hi  = longint'(max_thr);
    if (val < lo) val = lo;
    if (val > hi) val = hi;
    r.thrust = 16'(val);
    r.phase  = fl_phase;
    return r;
  endfunction

  always @(posedge clk) begin
    thrust_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (thrust_expected.size() == 0) begin
        $display("%0t: unexpected result: thrust %0d phase %0d invalid %0d", $time,
                 out_thrust_command, out_flight_phase, out_gain_invalid);
        mismatches++;
      end else begin
        want = thrust_expected.pop_front();
        if (out_thrust_command !== want.thrust) begin
          $display("%0t: thrust_command expected %0d actual %0d", $time, want.thrust,
                   out_thrust_command);
          mismatches++;
        end
        if (out_flight_phase !== want.phase) begin
          $display("%0t: flight_phase expected %0d actual %0d", $time, want.phase,
                   out_flight_phase);
          mismatches++;
        end
        if (out_gain_invalid !== want.invalid) begin
          $display("%0t: gain_invalid expected %0d actual %0d", $time, want.invalid,
                   out_gain_invalid);
          mismatches++;
        end
      end
    end
  end

  // Result side: random stalls per result, plus a long hold when one is requested.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      stall = rx_idle ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && rx_hold == 0);
    end
  end

  function automatic logic [15:0] span16(int lo, int hi);
    return 16'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  function automatic logic [15:0] any16();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_gain();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return span16(-4, 4);
      default: return any16();
    endcase
  endfunction

  function automatic logic hover_mode();
    return $urandom_range(0, 11) != 0;
  endfunction

  function automatic tick_t make_tick(logic mode, logic [15:0] cmd, logic [15:0] vx,
                                      logic [15:0] vy, logic [15:0] vz, logic [15:0] acc,
                                      logic [15:0] gain);
    tick_t t;
    t.mode = mode;
    t.cmd  = cmd;
    t.vx   = vx;
    t.vy   = vy;
    t.vz   = vz;
    t.acc  = acc;
    t.gain = gain;
    return t;
  endfunction

  function automatic tick_t random_tick(logic mode, logic [15:0] cmd);
    return make_tick(mode, cmd, any16(), any16(), any16(), any16(), random_gain());
  endfunction

  task automatic send_tick(input tick_t t);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_mode             <= t.mode;
    in_vertical_command <= t.cmd;
    in_vel_x            <= t.vx;
    in_vel_y            <= t.vy;
    in_vel_z            <= t.vz;
    in_accel_z_wanted   <= t.acc;
    in_accel_per_thrust <= t.gain;
    do @(posedge clk); while (!in_ready);
    thrust_expected.push_back(predict_thrust(t));
    ticks_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (thrust_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [THRUST_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MIN_THRUST:  min_thr  = data;
      REG_MAX_THRUST:  max_thr  = data;
      REG_RAMP_STEPS:  ramp_len = data[STEPS_W-1:0];
      REG_RAMP_FACTOR: ramp_fac = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_sequencer_config(int lo, int hi, int steps, int factor);
    wait_for_results();
    write_reg(REG_MIN_THRUST, THRUST_W'(lo));
    write_reg(REG_MAX_THRUST, THRUST_W'(hi));
    write_reg(REG_RAMP_STEPS, THRUST_W'(steps));
    write_reg(REG_RAMP_FACTOR, THRUST_W'(factor));
  endtask

  task automatic fly_one_profile();
    int guard;
    int cancel_at;
    logic [15:0] cmd;
    guard = 0;
    while (fl_phase == PH_GROUND && guard < 16) begin
      if ($urandom_range(0, 19) == 0) cmd = span16(-32768, 204);
      else if ($urandom_range(0, 5) == 0) cmd = 16'd205;
      else cmd = span16(205, 32767);
      send_tick(random_tick(hover_mode(), cmd));
      guard++;
    end
    guard = 0;
    cancel_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 20) : -1;
    while (fl_phase == PH_SLOW && guard < 64) begin
      cmd = (guard == cancel_at) ? span16(-32768, -205) : span16(-204, 32767);
      send_tick(random_tick(hover_mode(), cmd));
      guard++;
    end
    if (fl_phase == PH_SLOW) send_tick(random_tick(1'b1, span16(-32768, -205)));
    repeat ($urandom_range(0, 8)) send_tick(random_tick(hover_mode(), any16()));
    guard = 0;
    while (fl_phase == PH_FLYING && guard < 30) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: send_tick(make_tick(1'b1, span16(-2047, 32767), span16(-204, 204),
                                 span16(-204, 204), span16(-511, 32767), any16(),
                                 random_gain()));
          1: send_tick(make_tick(1'b1, span16(-32768, -2048), span16(-204, 204),
                                 span16(-204, 204), span16(-32768, -512), any16(),
                                 random_gain()));
          2: send_tick(make_tick(1'b1, span16(-32768, -2048), span16(205, 32767),
                                 span16(-204, 204), span16(-511, 32767), any16(),
                                 random_gain()));
          default: send_tick(make_tick(1'b1, span16(-32768, -2048), span16(-204, 204),
                                       span16(-32768, -205), span16(-511, 32767), any16(),
                                       random_gain()));
        endcase
      end else begin
        cmd = ($urandom_range(0, 5) == 0) ? 16'hF800 : span16(-32768, -2048);
        send_tick(make_tick(hover_mode(), cmd, span16(-204, 204), span16(-204, 204),
                            span16(-511, 32767), any16(), random_gain()));
      end
      guard++;
    end
  endtask

  task automatic run_flight_phase(int lo, int hi, int steps, int factor, int count);
    int start;
    load_sequencer_config(lo, hi, steps, factor);
    start = ticks_sent;
    while (ticks_sent - start < count) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 6)) send_tick(random_tick(1'($urandom_range(0, 1)),
                                                            any16()));
      end
      fly_one_profile();
    end
  endtask

  task automatic test_reset_values();
    send_tick(make_tick(1'b1, 16'd204, 16'd0, 16'd0, 16'd0, 16'h7FFF, 16'h0000));
    send_tick(make_tick(1'b0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000));
  endtask

  task automatic test_takeoff_ramp();
    load_sequencer_config(0, 65535, 1, 65535);
    repeat (11) send_tick(make_tick(1'b1, 16'd205, 16'h0000, 16'hFFFF, 16'h7FFF,
                                    16'd256, 16'd512));
    send_tick(make_tick(1'b1, 16'hFF34, 16'd0, 16'd0, 16'd0, 16'd256, 16'd512));
    send_tick(make_tick(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFF00, 16'hFE00));
  endtask

  task automatic test_quotient_extremes();
    send_tick(make_tick(1'b0, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0001));
    send_tick(make_tick(1'b0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0001));
    send_tick(make_tick(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000));
    send_tick(make_tick(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h7FFF));
    send_tick(make_tick(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h0000, 16'hFFFF));
    send_tick(make_tick(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd12345, 16'h0000));
    send_tick(make_tick(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFF00, 16'h0100));
    send_tick(make_tick(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd100, 16'h8000));
  endtask

  task automatic test_random_flights();
    run_flight_phase(0, 65535, 1, 65535, 300);
    run_flight_phase(3000, 50000, 6, 12000, 300);
    // Minimum above maximum: the maximum must win.
    run_flight_phase(60000, 2000, 2, 0, 250);
    run_flight_phase(0, 65535, 1023, 33000, 250);
    run_flight_phase($urandom_range(0, 8000), $urandom_range(30000, 65535),
                     $urandom_range(1, 12), $urandom_range(0, 65535), 300);
  endtask

  task automatic test_receiver_holdoff();
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold = 300;
    repeat (12) send_tick(random_tick(hover_mode(), any16()));
    wait_for_results();
  endtask

  task automatic test_sender_pause();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    repeat (20) send_tick(random_tick(1'($urandom_range(0, 1)), any16()));
    wait_for_results();
    tx_idle = 1'b0;
    repeat (20) send_tick(random_tick(1'($urandom_range(0, 1)), any16()));
    wait_for_results();
  endtask

  initial begin
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_mode             = 1'b0;
    in_vertical_command = '0;
    in_vel_x            = '0;
    in_vel_y            = '0;
    in_vel_z            = '0;
    in_accel_z_wanted   = '0;
    in_accel_per_thrust = '0;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    ticks_sent          = 0;
    tx_idle             = 1'b0;
    rx_idle             = 1'b0;
    rx_hold             = 0;
    reset_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_takeoff_ramp();
    test_quotient_extremes();
    test_receiver_holdoff();
    test_random_flights();
    test_sender_pause();
    wait_for_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && thrust_expected.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
